FILE: hdl/mskc_pkg.sv
package mskc_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int MAX_EDGES = 2048;
    localparam int EDGE_BITS = $clog2(MAX_EDGES);
    localparam int CNT_BITS  = EDGE_BITS + 1;
    localparam int COST_BITS = 16;
    localparam int CFG_BITS  = 7;
    localparam int EDGE_W    = 2 * NODE_BITS + COST_BITS;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic REG_NODE_COUNT     = 1'b0;
    localparam logic REG_CLUSTER_TARGET = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_LOOKA,
        S_LOOKB,
        S_CMP,
        S_RELABEL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic init_step;
        logic scan_start;
        logic scan_step;
        logic look_a;
        logic look_b;
        logic merge;
        logic relabel_step;
        logic set_err;
        logic set_exh;
        logic set_ok;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic err_now;
        logic last_in;
        logic sweep_done;
        logic scan_done;
        logic found;
        logic diff;
        logic merging;
        logic relabel_done;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: hdl/mskc_ram.sv
module mskc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mskc_ctrl.sv
module mskc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mskc_pkg::dp_sts_t sts,
    output mskc_pkg::dp_cmd_t cmd
);

    mskc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mskc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mskc_pkg::S_IDLE:
            begin
                if (in_valid && sts.last_in)
                begin
                    state_next = sts.err_now ? mskc_pkg::S_FINISH : mskc_pkg::S_INIT;
                end
            end
            mskc_pkg::S_INIT:
            begin
                if (sts.sweep_done)
                begin
                    state_next = mskc_pkg::S_SCAN;
                end
            end
            mskc_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.found ? mskc_pkg::S_LOOKA : mskc_pkg::S_FINISH;
                end
            end
            mskc_pkg::S_LOOKA:   state_next = mskc_pkg::S_LOOKB;
            mskc_pkg::S_LOOKB:   state_next = mskc_pkg::S_CMP;
            mskc_pkg::S_CMP:
            begin
                if (!sts.diff)
                begin
                    state_next = mskc_pkg::S_SCAN;
                end
                else if (sts.merging)
                begin
                    state_next = mskc_pkg::S_RELABEL;
                end
                else
                begin
                    state_next = mskc_pkg::S_FINISH;
                end
            end
            mskc_pkg::S_RELABEL:
            begin
                if (sts.relabel_done)
                begin
                    state_next = mskc_pkg::S_SCAN;
                end
            end
            mskc_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = mskc_pkg::S_IDLE;
                end
            end
            default: state_next = mskc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            mskc_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load    = in_valid;
                cmd.set_err = in_valid && sts.last_in && sts.err_now;
            end
            mskc_pkg::S_INIT:
            begin
                cmd.init_step  = 1'b1;
                cmd.scan_start = sts.sweep_done;
            end
            mskc_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.set_exh   = sts.scan_done && !sts.found;
            end
            mskc_pkg::S_LOOKA:   cmd.look_a = 1'b1;
            mskc_pkg::S_LOOKB:   cmd.look_b = 1'b1;
            mskc_pkg::S_CMP:
            begin
                cmd.scan_start = !sts.diff;
                cmd.merge      = sts.diff && sts.merging;
                cmd.set_ok     = sts.diff && !sts.merging;
            end
            mskc_pkg::S_RELABEL:
            begin
                cmd.relabel_step = 1'b1;
                cmd.scan_start   = sts.relabel_done;
            end
            mskc_pkg::S_FINISH:  cmd.finish = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hdl/mskc_dp.sv
module mskc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mskc_pkg::dp_cmd_t                    cmd,
    output mskc_pkg::dp_sts_t                    sts,
    input  logic [mskc_pkg::CFG_BITS-1:0]        node_count,
    input  logic [mskc_pkg::CFG_BITS-1:0]        cluster_target,
    input  logic [mskc_pkg::CFG_BITS-1:0]        from_node,
    input  logic [mskc_pkg::CFG_BITS-1:0]        to_node,
    input  logic [mskc_pkg::COST_BITS-1:0]       edge_cost,
    input  logic                                 last_edge,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mskc_pkg::COST_BITS-1:0]       spacing,
    output logic [1:0]                           status
);

    localparam int NB = mskc_pkg::NODE_BITS;
    localparam int CB = mskc_pkg::COST_BITS;

    logic [mskc_pkg::CNT_BITS-1:0]  count_reg;
    logic                           err_reg;
    logic [mskc_pkg::CFG_BITS-1:0]  clusters_reg;
    logic [NB:0]                    swp_reg;
    logic [mskc_pkg::CNT_BITS-1:0]  scan_reg;
    logic                           pend_reg;
    logic [mskc_pkg::EDGE_BITS-1:0] idx_d_reg;
    logic                           rl_pend_reg;
    logic [NB-1:0]                  rl_idx_reg;

    logic                           have_prev_reg, have_best_reg;
    logic [CB-1:0]                  prev_cost_reg, best_cost_reg;
    logic [mskc_pkg::EDGE_BITS-1:0] prev_idx_reg, best_idx_reg;
    logic [NB-1:0]                  best_a_reg, best_b_reg;
    logic [NB-1:0]                  la_reg, lb_reg;

    logic [CB-1:0]                  res_spacing_reg;
    logic [1:0]                     res_status_reg;
    logic                           out_valid_reg;
    logic [CB-1:0]                  spacing_reg;
    logic [1:0]                     status_reg;

    logic [mskc_pkg::CFG_BITS-1:0]  n_use;
    logic                           bad_node, full, store_ok;
    logic [mskc_pkg::EDGE_W-1:0]    edge_wdata, edge_rdata;
    logic                           scan_rd;
    logic [CB-1:0]                  e_cost;
    logic [NB-1:0]                  e_a, e_b;
    logic                           after_prev, better;
    logic                           lab_we;
    logic [NB-1:0]                  lab_waddr, lab_wdata, lab_raddr, lab_rdata;

    assign n_use = (node_count > mskc_pkg::CFG_BITS'(mskc_pkg::MAX_NODES))
                   ? mskc_pkg::CFG_BITS'(mskc_pkg::MAX_NODES) : node_count;
    assign bad_node = (from_node == '0) || (to_node == '0)
                      || (from_node > n_use) || (to_node > n_use);
    assign full     = (count_reg == mskc_pkg::CNT_BITS'(mskc_pkg::MAX_EDGES));
    assign store_ok = cmd.load && !bad_node && !full;

    assign edge_wdata = {NB'(from_node - 1'b1), NB'(to_node - 1'b1), edge_cost};

    mskc_ram #(.WIDTH(mskc_pkg::EDGE_W), .DEPTH(mskc_pkg::MAX_EDGES)) u_edges (
        .clk   (clk),
        .we    (store_ok),
        .waddr (count_reg[mskc_pkg::EDGE_BITS-1:0]),
        .wdata (edge_wdata),
        .raddr (scan_reg[mskc_pkg::EDGE_BITS-1:0]),
        .rdata (edge_rdata)
    );

    assign scan_rd = cmd.scan_step && (scan_reg < count_reg);
    assign e_a     = edge_rdata[mskc_pkg::EDGE_W-1 -: NB];
    assign e_b     = edge_rdata[CB +: NB];
    assign e_cost  = edge_rdata[CB-1:0];

    // next edge in (cost, arrival) order after the one last taken
    assign after_prev = !have_prev_reg || (e_cost > prev_cost_reg)
                        || ((e_cost == prev_cost_reg) && (idx_d_reg > prev_idx_reg));
    assign better     = !have_best_reg || (e_cost < best_cost_reg);

    // cluster label table
    always_comb
    begin
        lab_we    = 1'b0;
        lab_waddr = rl_idx_reg;
        lab_wdata = la_reg;
        if (cmd.init_step && !swp_reg[NB])
        begin
            lab_we    = 1'b1;
            lab_waddr = swp_reg[NB-1:0];
            lab_wdata = swp_reg[NB-1:0];
        end
        else if (cmd.relabel_step && rl_pend_reg && (lab_rdata == lb_reg))
        begin
            lab_we = 1'b1;
        end
        if (cmd.look_a)
        begin
            lab_raddr = best_a_reg;
        end
        else if (cmd.look_b)
        begin
            lab_raddr = best_b_reg;
        end
        else
        begin
            lab_raddr = swp_reg[NB-1:0];
        end
    end

    mskc_ram #(.WIDTH(NB), .DEPTH(mskc_pkg::MAX_NODES)) u_labels (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (lab_wdata),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            swp_reg       <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rl_pend_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load && (bad_node || full))
            begin
                err_reg <= 1'b1;
            end
            if (cmd.load && last_edge)
            begin
                swp_reg       <= '0;
                have_prev_reg <= 1'b0;
                have_best_reg <= 1'b0;
            end
            if (cmd.init_step && !swp_reg[NB])
            begin
                swp_reg <= swp_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_reg      <= '0;
                pend_reg      <= 1'b0;
                have_best_reg <= 1'b0;
                if (have_best_reg)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
            if (cmd.scan_step)
            begin
                pend_reg <= scan_rd;
                if (scan_rd)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (pend_reg && after_prev && better)
                begin
                    have_best_reg <= 1'b1;
                end
            end
            if (cmd.merge)
            begin
                swp_reg <= '0;
            end
            if (cmd.relabel_step)
            begin
                rl_pend_reg <= !swp_reg[NB];
                if (!swp_reg[NB])
                begin
                    swp_reg <= swp_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                err_reg       <= 1'b0;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && last_edge)
        begin
            clusters_reg <= n_use;
        end
        if (scan_rd)
        begin
            idx_d_reg <= scan_reg[mskc_pkg::EDGE_BITS-1:0];
        end
        if (cmd.scan_start && have_best_reg)
        begin
            prev_cost_reg <= best_cost_reg;
            prev_idx_reg  <= best_idx_reg;
        end
        if (cmd.scan_step && pend_reg && after_prev && better)
        begin
            best_cost_reg <= e_cost;
            best_idx_reg  <= idx_d_reg;
            best_a_reg    <= e_a;
            best_b_reg    <= e_b;
        end
        if (cmd.look_b)
        begin
            la_reg <= lab_rdata;
        end
        if (cmd.merge)
        begin
            lb_reg       <= lab_rdata;
            clusters_reg <= clusters_reg - 1'b1;
        end
        if (cmd.relabel_step)
        begin
            rl_idx_reg <= swp_reg[NB-1:0];
        end
        if (cmd.set_err || cmd.set_exh)
        begin
            res_status_reg  <= cmd.set_err ? mskc_pkg::ST_ERROR : mskc_pkg::ST_EXHAUST;
            res_spacing_reg <= '0;
        end
        if (cmd.set_ok)
        begin
            res_status_reg  <= mskc_pkg::ST_OK;
            res_spacing_reg <= best_cost_reg;
        end
        if (cmd.finish)
        begin
            spacing_reg <= res_spacing_reg;
            status_reg  <= res_status_reg;
        end
    end

    assign sts.err_now      = err_reg || bad_node || full;
    assign sts.last_in      = last_edge;
    assign sts.sweep_done   = swp_reg[NB];
    assign sts.scan_done    = !(scan_reg < count_reg) && !pend_reg;
    assign sts.found        = have_best_reg;
    assign sts.diff         = (la_reg != lab_rdata);
    assign sts.merging      = (clusters_reg > cluster_target);
    assign sts.relabel_done = swp_reg[NB] && !rl_pend_reg;
    assign sts.out_free     = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign spacing   = spacing_reg;
    assign status    = status_reg;

endmodule

FILE: hdl/max_spacing_k_clustering.sv
// loading: one edge word per cycle while idle, with in_stall high during a run; words
// with good endpoints (and room left) go straight into the edge store. the last edge starts a
// run, or after a bad word goes straight to an error result: label init, then for each
// edge taken a full store scan through the single edge-store read port to find the next
// edge in cost order, label lookup and compare, and a relabel on a merge while above target
// async active-low reset clears control state and sets node_count 64, target 4
module max_spacing_k_clustering (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // edge input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mskc_pkg::CFG_BITS-1:0]        from_node,
    input  logic [mskc_pkg::CFG_BITS-1:0]        to_node,
    input  logic [mskc_pkg::COST_BITS-1:0]       edge_cost,
    input  logic                                 last_edge,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mskc_pkg::COST_BITS-1:0]       spacing,
    output logic [1:0]                           status,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [mskc_pkg::CFG_BITS-1:0] node_count_reg;
    logic [mskc_pkg::CFG_BITS-1:0] cluster_target_reg;
    logic                          wr_en;
    mskc_pkg::dp_cmd_t             cmd;
    mskc_pkg::dp_sts_t             sts;

    // word index sits in paddr[2], byte lanes ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg     <= mskc_pkg::CFG_BITS'(64);
            cluster_target_reg <= mskc_pkg::CFG_BITS'(4);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                mskc_pkg::REG_NODE_COUNT:     node_count_reg     <= pwdata[mskc_pkg::CFG_BITS-1:0];
                mskc_pkg::REG_CLUSTER_TARGET: cluster_target_reg <= pwdata[mskc_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mskc_pkg::REG_NODE_COUNT:     prdata = 32'(node_count_reg);
            mskc_pkg::REG_CLUSTER_TARGET: prdata = 32'(cluster_target_reg);
            default:                      prdata = '0;
        endcase
    end

    // sequencer: load, init, scan, lookup, compare, relabel, finish
    mskc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // edge store, label table, scan and result registers
    mskc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .node_count     (node_count_reg),
        .cluster_target (cluster_target_reg),
        .from_node      (from_node),
        .to_node        (to_node),
        .edge_cost      (edge_cost),
        .last_edge      (last_edge),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .spacing        (spacing),
        .status         (status)
    );

    // the status code space has no fourth value
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("bad status code");

    // failed runs carry zero spacing
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != mskc_pkg::ST_OK)) |-> (spacing == '0))
        else $error("nonzero spacing with failure status");

    // a last edge always ends loading, so the input is held off next cycle
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_edge) |=> in_stall)
        else $error("input not held after last edge");

endmodule

FILE: tb/max_spacing_k_clustering_test.sv
module max_spacing_k_clustering_test;

    localparam int STALL_LIMIT = 2000000;

    typedef struct packed {
        logic [6:0]  from_node;
        logic [6:0]  to_node;
        logic [15:0] edge_cost;
        logic        last_edge;
    } edge_word_t;

    typedef struct packed {
        logic [15:0] spacing;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        int unsigned a;
        int unsigned b;
        int unsigned cost;
    } held_edge_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  from_node;
    logic [6:0]  to_node;
    logic [15:0] edge_cost;
    logic        last_edge;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] spacing;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_took;

    max_spacing_k_clustering u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .from_node (from_node),
        .to_node   (to_node),
        .edge_cost (edge_cost),
        .last_edge (last_edge),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .spacing   (spacing),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // pending edge words and expected spacing answers
    edge_word_t  edge_queue[$];
    answer_t     answer_queue[$];

    // shadow of the block state for prediction
    held_edge_t  shadow_edges[$];
    bit          shadow_err;
    int unsigned shadow_nodes;
    int unsigned shadow_target;
    int unsigned uf_parent[mskc_pkg::MAX_NODES];
    int unsigned uf_rank[mskc_pkg::MAX_NODES];

    int          mismatches;
    int          answers_seen;
    int          words_sent;
    int          idle_in_pct;
    int          stall_out_pct;
    int          quiet_cycles;
    bit          timed_out;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor: kruskal with union by rank and path compression
    // ---------------------------------------------------------------
    function automatic int unsigned uf_find(int unsigned x);
        int unsigned r;
        int unsigned nxt;
        int unsigned guard;
        r = x % mskc_pkg::MAX_NODES;
        guard = 0;
        while (uf_parent[r] != r && guard < mskc_pkg::MAX_NODES)
        begin
            r = uf_parent[r] % mskc_pkg::MAX_NODES;
            guard++;
        end
        x = x % mskc_pkg::MAX_NODES;
        while (x != r)
        begin
            nxt = uf_parent[x] % mskc_pkg::MAX_NODES;
            uf_parent[x] = r;
            x = nxt;
        end
        return r;
    endfunction

    function automatic answer_t cluster_spacing();
        held_edge_t  order[$];
        held_edge_t  e;
        answer_t     ans;
        int unsigned clusters;
        int unsigned p;
        int unsigned q;
        int          j;
        int          k;
        ans = '0;
        for (int i = 0; i < mskc_pkg::MAX_NODES; i++)
        begin
            uf_parent[i] = i;
            uf_rank[i] = 0;
        end
        clusters = shadow_nodes;
        // stable insertion sort by cost, ties keep arrival order
        foreach (shadow_edges[i])
        begin
            e = shadow_edges[i];
            j = order.size();
            while (j > 0 && order[j-1].cost > e.cost)
                j--;
            order.insert(j, e);
        end
        k = 0;
        while (clusters > shadow_target)
        begin
            if (k >= order.size())
            begin
                ans.status = mskc_pkg::ST_EXHAUST;
                return ans;
            end
            if (uf_find(order[k].a) != uf_find(order[k].b))
            begin
                p = uf_find(order[k].b);
                q = uf_find(order[k].a);
                if (uf_rank[p] > uf_rank[q])
                    uf_parent[q] = p;
                else
                begin
                    uf_parent[p] = q;
                    if (uf_rank[p] == uf_rank[q] && uf_rank[q] < 7)
                        uf_rank[q]++;
                end
                clusters--;
            end
            k++;
        end
        while (k < order.size())
        begin
            if (uf_find(order[k].a) != uf_find(order[k].b))
            begin
                ans.spacing = order[k].cost[15:0];
                ans.status = mskc_pkg::ST_OK;
                return ans;
            end
            k++;
        end
        ans.status = mskc_pkg::ST_EXHAUST;
        return ans;
    endfunction

    // applied to each word as it is accepted
    task automatic take_edge(input edge_word_t w);
        held_edge_t e;
        answer_t    ans;
        if (w.from_node == 0 || w.to_node == 0 ||
            w.from_node > shadow_nodes || w.to_node > shadow_nodes)
            shadow_err = 1'b1;
        else if (shadow_edges.size() >= mskc_pkg::MAX_EDGES)
            shadow_err = 1'b1;
        else
        begin
            e.a = w.from_node - 1;
            e.b = w.to_node - 1;
            e.cost = w.edge_cost;
            shadow_edges.push_back(e);
        end
        if (w.last_edge)
        begin
            if (shadow_err)
            begin
                ans = '0;
                ans.status = mskc_pkg::ST_ERROR;
            end
            else
                ans = cluster_spacing();
            answer_queue.push_back(ans);
            shadow_edges.delete();
            shadow_err = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on answer %0d: %s got %0d expected %0d",
                 answers_seen, what, got, want);
        mismatches++;
    endtask

    // acceptance is sampled here, then acted on at the next falling edge;
    // the handshake registers stay stable between the two
    always @(posedge clk)
        in_took <= in_valid && !in_stall;

    // ---------------------------------------------------------------
    // driver: new word at the falling edge, accepted at the rising edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
            begin
                take_edge({from_node, to_node, edge_cost, last_edge});
                words_sent++;
                quiet_cycles = 0;
                void'(edge_queue.pop_front());
            end
            // a held word stays put; otherwise maybe present the next one
            if (in_took || !in_valid)
            begin
                if (edge_queue.size() > 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    in_valid <= 1'b1;
                    {from_node, to_node, edge_cost, last_edge} <= edge_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_out_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: check each answer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (answer_queue.size() == 0)
                    report_mismatch("answer with none pending, status", status, -1);
                else
                begin
                    if (spacing !== answer_queue[0].spacing)
                        report_mismatch("spacing", spacing, answer_queue[0].spacing);
                    if (status !== answer_queue[0].status)
                        report_mismatch("status", status, answer_queue[0].status);
                    void'(answer_queue.pop_front());
                end
                answers_seen++;
            end
        end
    end

    // watchdog: no word accepted and no answer taken for too long
    always @(posedge clk)
    begin
        if (rst_n && quiet_cycles >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("watchdog: no progress, %0d answers pending", answer_queue.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // register write: setup phase then access phase
    task automatic write_reg(input logic idx, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mskc_pkg::REG_NODE_COUNT)
            shadow_nodes = (value & 7'h7f) > mskc_pkg::MAX_NODES ?
                           mskc_pkg::MAX_NODES : (value & 7'h7f);
        else
            shadow_target = value & 7'h7f;
    endtask

    // wait for every answer, then let the block settle
    task automatic drain();
        while (edge_queue.size() > 0 || answer_queue.size() > 0 || in_valid)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic edge_word_t make_edge(int unsigned a, int unsigned b,
                                             int unsigned c, bit last);
        edge_word_t w;
        w.from_node = 7'(a);
        w.to_node   = 7'(b);
        w.edge_cost = 16'(c);
        w.last_edge = last;
        return w;
    endfunction

    // random graph, edge total given by the caller; mostly good endpoints, rare noise when noisy is set
    task automatic queue_graph(int unsigned m, bit noisy, int unsigned cost_max);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        n = shadow_nodes;
        for (int i = 0; i < m; i++)
        begin
            a = $urandom_range(n, 1);
            b = $urandom_range(n, 1);
            if (noisy && $urandom_range(19) == 0)
                a = $urandom_range(127);
            if (noisy && $urandom_range(19) == 0)
                b = $urandom_range(127);
            edge_queue.push_back(make_edge(a, b, $urandom_range(cost_max), i == m - 1));
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        int unsigned n;

        rst_n = 1'b0;
        in_valid = 1'b0;
        from_node = '0;
        to_node = '0;
        edge_cost = '0;
        last_edge = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        answers_seen = 0;
        words_sent = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        idle_in_pct = 0;
        stall_out_pct = 0;
        shadow_nodes = 64;
        shadow_target = 4;
        shadow_err = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tiny graph on four nodes with target two, node extremes, full cost range
        write_reg(mskc_pkg::REG_NODE_COUNT, 4);
        write_reg(mskc_pkg::REG_CLUSTER_TARGET, 2);
        edge_queue.push_back(make_edge(1, 2, 16'hffff, 0));
        edge_queue.push_back(make_edge(3, 4, 0, 0));
        edge_queue.push_back(make_edge(2, 3, 7, 0));
        edge_queue.push_back(make_edge(1, 4, 7, 1));
        // bad node: zero endpoint, then one above the node count
        edge_queue.push_back(make_edge(0, 1, 5, 0));
        edge_queue.push_back(make_edge(1, 2, 5, 1));
        edge_queue.push_back(make_edge(1, 5, 5, 1));
        edge_queue.push_back(make_edge(127, 127, 5, 1));
        // edges run out: lone edge cannot reach the target
        edge_queue.push_back(make_edge(1, 2, 3, 1));
        // self loop only, no edge between distinct clusters
        edge_queue.push_back(make_edge(2, 2, 3, 1));
        drain();

        // target zero always exhausts
        write_reg(mskc_pkg::REG_CLUSTER_TARGET, 0);
        edge_queue.push_back(make_edge(1, 2, 9, 0));
        edge_queue.push_back(make_edge(2, 3, 9, 1));
        drain();
        // target at or above the node count: first distinct edge wins
        write_reg(mskc_pkg::REG_CLUSTER_TARGET, 127);
        edge_queue.push_back(make_edge(3, 3, 1, 0));
        edge_queue.push_back(make_edge(4, 1, 2, 1));
        drain();
        // node count zero makes every endpoint bad; too large acts as 64
        write_reg(mskc_pkg::REG_NODE_COUNT, 0);
        edge_queue.push_back(make_edge(1, 1, 1, 1));
        drain();
        write_reg(mskc_pkg::REG_NODE_COUNT, 127);
        write_reg(mskc_pkg::REG_CLUSTER_TARGET, 1);
        edge_queue.push_back(make_edge(64, 1, 16'h8000, 0));
        edge_queue.push_back(make_edge(64, 64, 16'h5555, 1));
        drain();

        // random: graphs in several idling phases and settings
        phase_idle  = '{0, 86, 0, 22};
        phase_stall = '{0, 0, 86, 22};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_in_pct = phase_idle[ph];
            stall_out_pct = phase_stall[ph];
            for (int g = 0; g < 14; g++)
            begin
                case ($urandom_range(3))
                    0: n = 2;
                    1: n = 64;
                    default: n = $urandom_range(12, 3);
                endcase
                write_reg(mskc_pkg::REG_NODE_COUNT, n);
                write_reg(mskc_pkg::REG_CLUSTER_TARGET, $urandom_range(3) == 0 ?
                          $urandom_range(127) : $urandom_range(n - 1, 1));
                // small graphs keep the quadratic compute short
                queue_graph(n == 64 ? $urandom_range(24, 8) : $urandom_range(3 * n, 1),
                            g % 3 == 0,
                            $urandom_range(1) ? 15 : 65535);
                drain();
            end
        end
        idle_in_pct = 0;
        stall_out_pct = 0;
        drain();

        $display("sent %0d edge words, checked %0d spacing answers", words_sent,
                 answers_seen);
        $display("covered bad nodes, exhausted edges, target and node count extremes");
        if (mismatches == 0 && answer_queue.size() == 0 && !timed_out)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/mskc_pkg.sv
hdl/mskc_ram.sv
hdl/mskc_ctrl.sv
hdl/mskc_dp.sv
hdl/max_spacing_k_clustering.sv
tb/max_spacing_k_clustering_test.sv
